### rtl/fpr_pkg.sv
// shared types and constants of the fifo page replacement unit
package fpr_pkg;

  // fixed widths of the transaction fields
  localparam int unsigned PAGE_W  = 16;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned FCFG_W  = 4;

  // frame count after reset
  localparam logic [FCFG_W-1:0] FRAME_COUNT_RST = 4'd8;

  // control flags that travel with a lookup token along the cell row
  typedef struct packed {
    logic vld;
    logic hit;
  } fpr_flags_t;

  // one finished result
  typedef struct packed {
    logic              hit;
    logic              ev_valid;
    logic [PAGE_W-1:0] ev_page;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  fault_count;
    logic [CNT_W-1:0]  hit_count;
  } fpr_result_t;

endpackage

### rtl/fpr_req_if.sv
// page reference channel: valid, ready and the page number
interface fpr_req_if import fpr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page;

  modport source (output valid, output page, input ready);
  modport sink   (input valid, input page, output ready);
endinterface

### rtl/fpr_rsp_if.sv
// result channel: valid, ready and the lookup result fields
interface fpr_rsp_if import fpr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic              evicted_valid;
  logic [PAGE_W-1:0] evicted_page;
  logic [SLOT_W-1:0] slot;
  logic [CNT_W-1:0]  fault_count;
  logic [CNT_W-1:0]  hit_count;

  modport source (output valid, output hit, output evicted_valid, output evicted_page,
                  output slot, output fault_count, output hit_count, input ready);
  modport sink   (input valid, input hit, input evicted_valid, input evicted_page,
                  input slot, input fault_count, input hit_count, output ready);
endinterface

### rtl/fifo_page_replacement.sv
// fifo page replacement unit: top level with the cell row and result buffering
// a page reference walks the row of FRAMES cells, one cell a cycle; when it leaves the row
//   its result is registered in the output buffer
// one transaction at a time: the next is taken only once the last has left the cell row
// a finished result waits in a two-entry output buffer while the next lookup runs
// reset: table empty, fill level and oldest slot zero, counts zero, frame count 8
module fifo_page_replacement import fpr_pkg::*; #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  fpr_req_if.sink           req,
  fpr_rsp_if.source         rsp,
  input  logic              cfg_we_i,
  input  logic [FCFG_W-1:0] cfg_wdata_i
);

  localparam int unsigned PW = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
  localparam int unsigned IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned FW = $clog2(FRAMES + 1);

  logic [FCFG_W-1:0] frame_count_q;
  logic [FW-1:0]     fill_q;
  logic [IW-1:0]     oldest_q;
  logic [CNT_W-1:0]  faults_q;
  logic [CNT_W-1:0]  hits_q;
  logic              busy_q;
  logic              out_vld_q;
  logic              pend_vld_q;
  fpr_result_t       out_q;
  fpr_result_t       pend_q;

  logic [FW-1:0] frames;
  logic          full;
  logic          accept;

  // token row, index k is the input of cell k
  fpr_flags_t    fl   [FRAMES+1];
  logic [PW-1:0] pg   [FRAMES+1];
  logic [FW-1:0] fil  [FRAMES+1];
  logic [IW-1:0] vic  [FRAMES+1];
  logic [IW-1:0] hsl  [FRAMES+1];
  logic [PW-1:0] evp  [FRAMES+1];

  logic          exit_vld;
  logic          exit_hit;
  logic          evict;
  logic          wr_en;
  logic [FW-1:0] oldest_inc;
  logic [CNT_W-1:0] faults_nx;
  logic [CNT_W-1:0] hits_nx;
  fpr_result_t   res;
  logic          out_free;

  // active frames: zero acts as one, above FRAMES acts as FRAMES
  always_comb begin
    if (frame_count_q == '0) begin
      frames = FW'(1);
    end else if (int'(frame_count_q) > int'(FRAMES)) begin
      frames = FW'(FRAMES);
    end else begin
      frames = FW'(frame_count_q);
    end
  end

  assign full      = (fill_q >= frames);
  assign req.ready = !busy_q && !pend_vld_q;
  assign accept    = req.valid && req.ready;

  // token injection at the head of the row
  assign fl[0].vld = accept;
  assign fl[0].hit = 1'b0;
  assign pg[0]     = PW'(req.page);
  assign fil[0]    = fill_q;
  assign vic[0]    = full ? oldest_q : IW'(fill_q);
  assign hsl[0]    = '0;
  assign evp[0]    = '0;

  // row of frame cells
  for (genvar k = 0; k < FRAMES; k++) begin : g_cell
    fpr_cell #(
      .PW  (PW),
      .IW  (IW),
      .FW  (FW),
      .IDX (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .flags_i    (fl[k]),
      .page_i     (pg[k]),
      .fill_i     (fil[k]),
      .victim_i   (vic[k]),
      .hit_slot_i (hsl[k]),
      .ev_page_i  (evp[k]),
      .flags_o    (fl[k+1]),
      .page_o     (pg[k+1]),
      .fill_o     (fil[k+1]),
      .victim_o   (vic[k+1]),
      .hit_slot_o (hsl[k+1]),
      .ev_page_o  (evp[k+1]),
      .wr_en_i    (wr_en),
      .wr_slot_i  (vic[FRAMES]),
      .wr_page_i  (pg[FRAMES])
    );
  end

  // result of the token leaving the row
  assign exit_vld   = fl[FRAMES].vld;
  assign exit_hit   = fl[FRAMES].hit;
  assign evict      = !exit_hit && (fil[FRAMES] >= frames);
  assign wr_en      = exit_vld && !exit_hit;
  assign oldest_inc = FW'(vic[FRAMES]) + FW'(1);
  assign faults_nx  = (!exit_hit && (faults_q != '1)) ? faults_q + CNT_W'(1) : faults_q;
  assign hits_nx    = (exit_hit && (hits_q != '1)) ? hits_q + CNT_W'(1) : hits_q;

  always_comb begin
    res.hit         = exit_hit;
    res.ev_valid    = evict;
    res.ev_page     = evict ? PAGE_W'(evp[FRAMES]) : '0;
    res.slot        = exit_hit ? SLOT_W'(hsl[FRAMES]) : SLOT_W'(vic[FRAMES]);
    res.fault_count = faults_nx;
    res.hit_count   = hits_nx;
  end

  // table state, counters and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= FRAME_COUNT_RST;
      fill_q        <= '0;
      oldest_q      <= '0;
      faults_q      <= '0;
      hits_q        <= '0;
      busy_q        <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (exit_vld) begin
        busy_q <= 1'b0;
      end
      if (exit_vld) begin
        faults_q <= faults_nx;
        hits_q   <= hits_nx;
        if (!exit_hit) begin
          if (evict) begin
            oldest_q <= (oldest_inc == frames) ? '0 : IW'(oldest_inc);
          end else begin
            fill_q <= fill_q + FW'(1);
          end
        end
      end
      if (cfg_we_i) begin
        frame_count_q <= cfg_wdata_i;
        fill_q        <= '0;
        oldest_q      <= '0;
      end
    end
  end

  assign out_free = !out_vld_q || rsp.ready;

  // output buffer valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      if (exit_vld) begin
        if (out_free) begin
          out_vld_q <= 1'b1;
        end else begin
          pend_vld_q <= 1'b1;
        end
      end else if (pend_vld_q && out_free) begin
        out_vld_q  <= 1'b1;
        pend_vld_q <= 1'b0;
      end else if (out_vld_q && rsp.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // output buffer payload
  always_ff @(posedge clk_i) begin
    if (exit_vld) begin
      if (out_free) begin
        out_q <= res;
      end else begin
        pend_q <= res;
      end
    end else if (pend_vld_q && out_free) begin
      out_q <= pend_q;
    end
  end

  assign rsp.valid         = out_vld_q;
  assign rsp.hit           = out_q.hit;
  assign rsp.evicted_valid = out_q.ev_valid;
  assign rsp.evicted_page  = out_q.ev_page;
  assign rsp.slot          = out_q.slot;
  assign rsp.fault_count   = out_q.fault_count;
  assign rsp.hit_count     = out_q.hit_count;

endmodule

### rtl/fpr_cell.sv
// one frame cell: holds a resident page, checks the passing token, hands it on
module fpr_cell import fpr_pkg::*; #(
  parameter int unsigned PW  = 16,
  parameter int unsigned IW  = 3,
  parameter int unsigned FW  = 4,
  parameter int unsigned IDX = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  fpr_flags_t    flags_i,
  input  logic [PW-1:0] page_i,
  input  logic [FW-1:0] fill_i,
  input  logic [IW-1:0] victim_i,
  input  logic [IW-1:0] hit_slot_i,
  input  logic [PW-1:0] ev_page_i,
  output fpr_flags_t    flags_o,
  output logic [PW-1:0] page_o,
  output logic [FW-1:0] fill_o,
  output logic [IW-1:0] victim_o,
  output logic [IW-1:0] hit_slot_o,
  output logic [PW-1:0] ev_page_o,
  input  logic          wr_en_i,
  input  logic [IW-1:0] wr_slot_i,
  input  logic [PW-1:0] wr_page_i
);

  localparam logic [IW-1:0] MY_SLOT = IW'(IDX);
  localparam logic [FW-1:0] MY_POS  = FW'(IDX);

  logic [PW-1:0] entry_q;
  fpr_flags_t    flags_q;
  logic [PW-1:0] page_q;
  logic [FW-1:0] fill_q;
  logic [IW-1:0] victim_q;
  logic [IW-1:0] hit_slot_q;
  logic [PW-1:0] ev_page_q;
  logic          match;

  // entry is resident only below the fill level
  assign match = (fill_i > MY_POS) && (entry_q == page_i);

  // token flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q.vld <= flags_i.vld;
      flags_q.hit <= flags_i.hit | match;
    end
  end

  // token payload, picks up hit slot and victim page on the way
  always_ff @(posedge clk_i) begin
    page_q     <= page_i;
    fill_q     <= fill_i;
    victim_q   <= victim_i;
    hit_slot_q <= match ? MY_SLOT : hit_slot_i;
    ev_page_q  <= (victim_i == MY_SLOT) ? entry_q : ev_page_i;
  end

  // resident page store, written back after a fault
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_slot_i == MY_SLOT)) begin
      entry_q <= wr_page_i;
    end
  end

  assign flags_o    = flags_q;
  assign page_o     = page_q;
  assign fill_o     = fill_q;
  assign victim_o   = victim_q;
  assign hit_slot_o = hit_slot_q;
  assign ev_page_o  = ev_page_q;

endmodule

### rtl/fpr_checker.sv
// port-level checks of the fifo page replacement unit and their binding
module fpr_checker import fpr_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              hit_i,
  input logic              ev_valid_i,
  input logic [PAGE_W-1:0] ev_page_i,
  input logic [CNT_W-1:0]  fault_count_i,
  input logic [CNT_W-1:0]  hit_count_i
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(fault_count_i)
      && $stable(hit_count_i) && $stable(hit_i))
    else $error("stalled result changed");

  // one lookup at a time: no accept right after an accept
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("accepted back to back");

  // an eviction only happens on a fault
  a_evict_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ev_valid_i |-> !hit_i && (fault_count_i != '0))
    else $error("eviction on a hit");

  // no eviction reports page zero
  a_ev_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !ev_valid_i |-> ev_page_i == '0)
    else $error("evicted page without eviction");

  // a hit is counted in its own result
  a_hit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && hit_i |-> hit_count_i != '0)
    else $error("hit not counted");

endmodule

bind fifo_page_replacement fpr_checker u_fpr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (req.valid),
  .in_ready_i    (req.ready),
  .out_valid_i   (rsp.valid),
  .out_ready_i   (rsp.ready),
  .hit_i         (rsp.hit),
  .ev_valid_i    (rsp.evicted_valid),
  .ev_page_i     (rsp.evicted_page),
  .fault_count_i (rsp.fault_count),
  .hit_count_i   (rsp.hit_count)
);

### bench/testbench.sv
`timescale 1ns / 1ps
// testbench of the fifo page replacement unit: directed page table, random page streams, scoreboard
module testbench;
  import fpr_pkg::*;

  localparam int unsigned FRAMES          = 8;
  localparam int unsigned NUM_SETTINGS    = 13;
  localparam int unsigned NUM_ROWS        = 15;
  localparam int unsigned PAGES_PER_PHASE = 150;
  localparam int unsigned DRAIN_CYCLES    = FRAMES + 4;
  localparam int unsigned CYCLE_LIMIT     = 600000;
  localparam int unsigned HOLD_AT_RESULT  = 240;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned MAX_REPORTS     = 40;

  // one row of the directed table: page, whether the result is typed in, typed result
  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              known;
    fpr_result_t       res;
  } page_row_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [FCFG_W-1:0] cfg_wdata_i = '0;

  fpr_req_if req_ch ();
  fpr_rsp_if rsp_ch ();

  fifo_page_replacement #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_W)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // shadow of the frame table and counters
  logic [PAGE_W-1:0] resident_pages [FRAMES];
  logic [FCFG_W-1:0] frame_count_q  = FRAME_COUNT_RST;
  int unsigned       fill_level_q   = 0;
  int unsigned       oldest_slot_q  = 0;
  logic [CNT_W-1:0]  faults_seen_q  = '0;
  logic [CNT_W-1:0]  hits_seen_q    = '0;

  // scoreboard state
  fpr_result_t expected_results [$];
  fpr_result_t oldest_expected;
  int unsigned mismatches     = 0;
  int unsigned pages_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 37;
  int unsigned recv_idle_pct  = 69;
  bit          hold_on        = 1'b0;

  // directed rows at frame count 8, starting from an empty table
  page_row_t directed_rows [NUM_ROWS] = '{
    '{16'h0000, 1'b1, '{1'b0, 1'b0, 16'h0000, 3'd0, 32'd1,  32'd0}},
    '{16'hFFFF, 1'b1, '{1'b0, 1'b0, 16'h0000, 3'd1, 32'd2,  32'd0}},
    '{16'h0000, 1'b1, '{1'b1, 1'b0, 16'h0000, 3'd0, 32'd2,  32'd1}},
    '{16'hFFFF, 1'b1, '{1'b1, 1'b0, 16'h0000, 3'd1, 32'd2,  32'd2}},
    '{16'h5555, 1'b0, '0},
    '{16'hAAAA, 1'b0, '0},
    '{16'h0001, 1'b0, '0},
    '{16'h8000, 1'b0, '0},
    '{16'h00FF, 1'b0, '0},
    '{16'hFF00, 1'b0, '0},
    // table full: oldest page goes out
    '{16'h1234, 1'b1, '{1'b0, 1'b1, 16'h0000, 3'd0, 32'd9,  32'd2}},
    '{16'hFFFF, 1'b0, '0},
    '{16'h0000, 1'b1, '{1'b0, 1'b1, 16'hFFFF, 3'd1, 32'd10, 32'd3}},
    '{16'h1234, 1'b0, '0},
    '{16'hFFFF, 1'b0, '0}
  };

  // frame count settings for the random phases, extremes included
  logic [FCFG_W-1:0] frame_settings [NUM_SETTINGS] = '{
    4'd1, 4'd0, 4'd15, 4'd8, 4'd3, 4'd5, 4'd2, 4'd9, 4'd4, 4'd7, 4'd6, 4'd12, 4'd8
  };

  // number of frames that a frame count setting really uses
  function automatic int unsigned frames_in_use(input logic [FCFG_W-1:0] count);
    if (count == 0) return 1;
    if (count > FRAMES) return FRAMES;
    return int'(count);
  endfunction

  // fifo replacement lookup on the shadow table, returns the expected result
  function automatic fpr_result_t lookup_page(input logic [PAGE_W-1:0] page);
    fpr_result_t r;
    int unsigned active;
    int unsigned victim;
    int unsigned i;
    r = '0;
    active = frames_in_use(frame_count_q);
    for (i = 0; i < fill_level_q && i < FRAMES; i++) begin
      if (!r.hit && resident_pages[i] == page) begin
        r.hit  = 1'b1;
        r.slot = SLOT_W'(i);
      end
    end
    if (r.hit) begin
      if (hits_seen_q != '1) hits_seen_q++;
    end else begin
      if (faults_seen_q != '1) faults_seen_q++;
      if (fill_level_q < active) begin
        r.slot = SLOT_W'(fill_level_q);
        resident_pages[fill_level_q] = page;
        fill_level_q++;
      end else begin
        victim = oldest_slot_q % active;
        r.slot = SLOT_W'(victim);
        r.ev_valid = 1'b1;
        r.ev_page = resident_pages[victim];
        resident_pages[victim] = page;
        oldest_slot_q = (victim + 1) % active;
      end
    end
    r.fault_count = faults_seen_q;
    r.hit_count = hits_seen_q;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
                                 input logic [CNT_W-1:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch at result %0d on %s: got %h, expected %h", results_seen, what, got, want);
  endtask

  // offer one page reference and record its expected result on acceptance
  task automatic offer_page(input logic [PAGE_W-1:0] page, input logic known,
                            input fpr_result_t typed);
    fpr_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.page  <= page;
    do @(posedge clk_i); while (!req_ch.ready);
    predicted = lookup_page(page);
    expected_results = {expected_results, (known ? typed : predicted)};
    pages_sent++;
  endtask

  // stop offering and wait until every result is back and the row is empty
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // result side: check each transaction, random stalls, long hold-off when asked
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with no page reference waiting", '0, '0);
        end else begin
          oldest_expected = expected_results.pop_front();
          if (rsp_ch.hit !== oldest_expected.hit)
            report_mismatch("hit", CNT_W'(rsp_ch.hit), CNT_W'(oldest_expected.hit));
          if (rsp_ch.evicted_valid !== oldest_expected.ev_valid)
            report_mismatch("evicted_valid", CNT_W'(rsp_ch.evicted_valid),
                            CNT_W'(oldest_expected.ev_valid));
          if (rsp_ch.evicted_page !== oldest_expected.ev_page)
            report_mismatch("evicted_page", CNT_W'(rsp_ch.evicted_page),
                            CNT_W'(oldest_expected.ev_page));
          if (rsp_ch.slot !== oldest_expected.slot)
            report_mismatch("slot", CNT_W'(rsp_ch.slot), CNT_W'(oldest_expected.slot));
          if (rsp_ch.fault_count !== oldest_expected.fault_count)
            report_mismatch("fault_count", rsp_ch.fault_count, oldest_expected.fault_count);
          if (rsp_ch.hit_count !== oldest_expected.hit_count)
            report_mismatch("hit_count", rsp_ch.hit_count, oldest_expected.hit_count);
        end
      end
      if (hold_on) begin
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // one long result hold-off while the sender keeps offering
  initial begin
    wait (results_seen == HOLD_AT_RESULT);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("[fifo_page_replacement] ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [PAGE_W-1:0] page_pool [$];
    logic [PAGE_W-1:0] page;
    int unsigned       pool_size;
    int unsigned       pick;
    req_ch.valid  = 1'b0;
    req_ch.page   = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at the reset frame count
    for (int r = 0; r < NUM_ROWS; r++)
      offer_page(directed_rows[r].page, directed_rows[r].known, directed_rows[r].res);
    drain_results();

    // random phases, one frame count setting each
    for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
      if (ph < 4) begin
        send_idle_pct = 37;
        recv_idle_pct = 69;
      end else if (ph < 8) begin
        send_idle_pct = 69;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      // frame count write empties the table, counts are kept
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= frame_settings[ph];
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      frame_count_q = frame_settings[ph];
      fill_level_q  = 0;
      oldest_slot_q = 0;

      // a small working set around the frame count gives both hits and evictions
      page_pool.delete();
      pool_size = frames_in_use(frame_settings[ph]) + $urandom_range(0, 3);
      repeat (pool_size) page_pool = {page_pool, PAGE_W'($urandom())};

      repeat (PAGES_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 80)
          page = page_pool[$urandom_range(page_pool.size() - 1)];
        else if (pick < 90)
          page = PAGE_W'($urandom());
        else
          page = page_pool[$urandom_range(page_pool.size() - 1)]
                 ^ (PAGE_W'(1) << $urandom_range(PAGE_W - 1));
        offer_page(page, 1'b0, '0);
      end
      drain_results();
    end

    $display("covered %0d page references over %0d frame count settings, %0d results checked",
             pages_sent, NUM_SETTINGS + 1, results_seen);
    $display("hits %0d, faults %0d, with stalls on both sides and one long result hold-off",
             hits_seen_q, faults_seen_q);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[fifo_page_replacement] OK");
    end else begin
      $display("[fifo_page_replacement] ERROR");
    end
    $finish;
  end

endmodule
